/* src/assert_macros.svh */
// Assertion macros used by the checker module of the pixel format converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: label");

// Property checked only while the active-low reset is released.
`define ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

`endif

/* src/pfc_pkg.sv */
// Package with the format codes and register indexes of the pixel format converter.
`default_nettype none

package pfc_pkg;

    // Pixel format codes, shared by the source and destination registers.
    typedef enum logic [2:0] {
        FMT_A8       = 3'd0,
        FMT_RGB888   = 3'd1,
        FMT_RGB565   = 3'd2,
        FMT_RGBA5551 = 3'd3,
        FMT_RGBA4444 = 3'd4,
        FMT_RGBA8888 = 3'd5
    } t_fmt;

    localparam int unsigned FmtW    = 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned PixW    = 32;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_SRC_FORMAT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DST_FORMAT = 2'd1;

endpackage

`default_nettype wire

/* src/pfc_unpack.sv */
// Unpacks a raw source pixel into canonical RGBA8888 (red in the low byte).
`default_nettype none

module pfc_unpack
    import pfc_pkg::*;
(
    input  wire  [PixW-1:0] i_pixel,
    input  t_fmt            i_fmt,
    output logic [PixW-1:0] o_canon
);

    // Narrow channels widen by a left shift; formats without alpha get 255.
    always_comb begin
        case (i_fmt)
            FMT_A8: begin
                o_canon = {i_pixel[7:0], 24'h000000};
            end
            FMT_RGB888: begin
                o_canon = {8'hFF, i_pixel[23:0]};
            end
            FMT_RGB565: begin
                o_canon = {8'hFF, i_pixel[4:0], 3'b000, i_pixel[10:5], 2'b00,
                           i_pixel[15:11], 3'b000};
            end
            FMT_RGBA5551: begin
                o_canon = {{8{i_pixel[15]}}, i_pixel[14:10], 3'b000,
                           i_pixel[9:5], 3'b000, i_pixel[4:0], 3'b000};
            end
            FMT_RGBA4444: begin
                o_canon = {i_pixel[3:0], 4'h0, i_pixel[7:4], 4'h0,
                           i_pixel[11:8], 4'h0, i_pixel[15:12], 4'h0};
            end
            FMT_RGBA8888: begin
                o_canon = i_pixel;
            end
            default: begin
                o_canon = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/pfc_pack.sv */
// Packs a canonical RGBA8888 pixel into the destination format.
`default_nettype none

module pfc_pack
    import pfc_pkg::*;
(
    input  wire  [PixW-1:0] i_canon,
    input  t_fmt            i_fmt,
    output logic [PixW-1:0] o_pixel
);

    // Each channel keeps its top bits; the 5551 alpha bit is set by any
    // nonzero bit in the top alpha nibble.
    always_comb begin
        case (i_fmt)
            FMT_A8: begin
                o_pixel = {24'h000000, i_canon[31:24]};
            end
            FMT_RGB888: begin
                o_pixel = {8'h00, i_canon[23:0]};
            end
            FMT_RGB565: begin
                o_pixel = {16'h0000, i_canon[7:3], i_canon[15:10], i_canon[23:19]};
            end
            FMT_RGBA5551: begin
                o_pixel = {16'h0000, |i_canon[31:28], i_canon[23:19],
                           i_canon[15:11], i_canon[7:3]};
            end
            FMT_RGBA4444: begin
                o_pixel = {16'h0000, i_canon[7:4], i_canon[15:12],
                           i_canon[23:20], i_canon[31:28]};
            end
            FMT_RGBA8888: begin
                o_pixel = i_canon;
            end
            default: begin
                o_pixel = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/pixel_format_converter.sv */
// Top level of the pixel format converter: input register, conversion, result register.
//
// Usage:
//   The slave stream carries one raw pixel per item in s_axis_tdata with its
//   run marker in s_axis_tlast. The master stream returns, per item, the pixel
//   packed in the destination format (tdata bits 31:0), the canonical RGBA8888
//   word (tdata bits 63:32) and the copied marker in m_axis_tlast.
//   Source and destination formats are set through the write port (index 0
//   and 1); the user must write them only while no item is in flight, which
//   the block itself does not enforce; writes to other indexes are dropped.
//   An accepted item passes the two-register path (input register, unpack
//   and pack logic, result register). One item is accepted every cycle
//   while the receiver does not stall.
//   Reset empties both registers and sets both formats to RGBA8888.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item, so s_axis_tready drops only
//   when both registers are full.
`default_nettype none

module pixel_format_converter
    import pfc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    // Configuration write port.
    input  wire                i_cfg_we,
    input  wire  [CfgIdxW-1:0] i_cfg_index,
    input  wire  [FmtW-1:0]    i_cfg_wdata,
    // Slave stream.
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  [31:0]        s_axis_tdata,   // [31:0] pixel_in
    input  wire                s_axis_tlast,
    // Master stream.
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    output logic [63:0]        m_axis_tdata,   // [31:0] pixel_out, [63:32] canonical_rgba
    output logic               m_axis_tlast
);

    t_fmt             r_src_fmt;
    t_fmt             r_dst_fmt;
    logic             r_in_valid;
    logic [PixW-1:0]  r_in_pixel;
    logic             r_in_last;
    logic             r_out_valid;
    logic [PixW-1:0]  r_out_pixel;
    logic [PixW-1:0]  r_out_canon;
    logic             r_out_last;
    logic             n_in_valid;
    logic             n_out_valid;
    logic             in_take;
    logic             s1_move;
    logic [PixW-1:0]  canon;
    logic [PixW-1:0]  packed_pixel;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_RGBA8888;
            r_dst_fmt <= FMT_RGBA8888;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SRC_FORMAT) begin
                r_src_fmt <= t_fmt'(i_cfg_wdata);
            end
            if (i_cfg_index == CFG_DST_FORMAT) begin
                r_dst_fmt <= t_fmt'(i_cfg_wdata);
            end
        end
    end

    // Handshake: the input register moves on when the result register is
    // free or being drained this cycle.
    always_comb begin
        s1_move       = r_in_valid && (!r_out_valid || m_axis_tready);
        s_axis_tready = !r_in_valid || s1_move;
        in_take       = s_axis_tvalid && s_axis_tready;
        n_in_valid    = in_take || (r_in_valid && !s1_move);
        n_out_valid   = s1_move || (r_out_valid && !m_axis_tready);
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pixel <= s_axis_tdata;
            r_in_last  <= s_axis_tlast;
        end
    end

    // Conversion logic between the two registers.
    pfc_unpack u_unpack (
        .i_pixel (r_in_pixel),
        .i_fmt   (r_src_fmt),
        .o_canon (canon)
    );

    pfc_pack u_pack (
        .i_canon (canon),
        .i_fmt   (r_dst_fmt),
        .o_pixel (packed_pixel)
    );

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_pixel <= packed_pixel;
            r_out_canon <= canon;
            r_out_last  <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_canon, r_out_pixel};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* src/pfc_checker.sv */
// Port-level checker for the pixel format converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pfc_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               s_axis_tvalid,
    input wire               s_axis_tready,
    input wire               m_axis_tvalid,
    input wire               m_axis_tready,
    input wire [63:0]        m_axis_tdata,
    input wire               m_axis_tlast
);

    // A stalled result keeps its payload.
    `ASSERT_RUN(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))

    // Reset empties the result register.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> (!m_axis_tvalid))

    // With no result waiting, the input side is always open.
    `ASSERT_RUN(a_no_bubble, i_clk, i_rst_n, (!m_axis_tvalid) |-> s_axis_tready)

    // An accepted item moves through the input register to the output when the receiver is ready in between.
    `ASSERT_RUN(a_latency, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready ##1 m_axis_tready) |=> m_axis_tvalid)

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (.*);

`default_nettype wire
